// File: hw/rtl/chcc_pkg.sv
// Shared types, constants and helpers for the coordinate hill-climb controller.
`timescale 1ns / 1ps
`default_nettype none
package chcc_pkg;

    localparam int MAX_VARS = 16;
    localparam int VAR_AW = $clog2(MAX_VARS);
    localparam int CNT_W = VAR_AW + 1;
    localparam int VAL_W = 32;
    localparam int COST_W = 40;
    localparam int STEP_W = 31;
    localparam int NRES = 3;

    localparam logic [COST_W-1:0] COST_ONE = 40'd65536;
    localparam logic [COST_W-1:0] COST_CEILING = 40'd6553600000;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_REPORT = 2'd2;

    localparam logic [1:0] CFG_NUM_VARS = 2'd0;
    localparam logic [1:0] CFG_INIT_STEP = 2'd1;
    localparam logic [1:0] CFG_STOP_STEP = 2'd2;

    localparam logic [STEP_W-1:0] INIT_STEP_RST = 31'd65536;
    localparam logic [STEP_W-1:0] STOP_STEP_RST = 31'd16384;

    typedef enum logic [1:0] {
        ACT_EVAL = 2'd0,
        ACT_SET  = 2'd1,
        ACT_DONE = 2'd2
    } act_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_FIN,
        OP_START,
        OP_NEG,
        OP_NEXT,
        OP_RFIN,
        OP_CFIN,
        OP_CNEXT
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [VAR_AW-1:0]  idx;
        logic [VAR_AW-1:0]  pidx;
        logic               neg_b;
        logic               newbest;
        logic [STEP_W-1:0]  step_a;
        logic [STEP_W-1:0]  step_b;
        logic [VAL_W-1:0]   value;
        logic [COST_W-1:0]  cost;
    } item_t;

    typedef struct packed {
        logic               re;
        logic [VAR_AW-1:0]  addr;
    } mem_rd_t;

    typedef struct packed {
        logic               we;
        logic [VAR_AW-1:0]  addr;
        logic [VAL_W-1:0]   data;
    } mem_wr_t;

    typedef struct packed {
        act_t               act;
        logic [VAR_AW-1:0]  idx;
        logic [VAL_W-1:0]   val;
        logic [COST_W-1:0]  cost;
    } res_t;

    // value +/- step, saturated to the signed 32-bit range
    function automatic logic [VAL_W-1:0] moved(input logic [VAL_W-1:0] v, input logic neg,
                                               input logic [STEP_W-1:0] step);
        logic [VAL_W:0] s;
        logic [VAL_W-1:0] r;
        if (neg) begin
            s = {v[VAL_W-1], v} - {2'b00, step};
        end else begin
            s = {v[VAL_W-1], v} + {2'b00, step};
        end
        if (s[VAL_W] != s[VAL_W-1]) begin
            r = s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end else begin
            r = s[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/chcc_var_mem.sv
// Variable store: one write port, one registered read port with write-first forwarding.
`timescale 1ns / 1ps
`default_nettype none
module chcc_var_mem (
    input  wire logic                          aclk,
    input  wire chcc_pkg::mem_rd_t             rd,
    input  wire chcc_pkg::mem_wr_t             wr,
    output logic [chcc_pkg::VAL_W-1:0]         rd_data
);

    logic [chcc_pkg::VAL_W-1:0] mem [chcc_pkg::MAX_VARS];
    logic [chcc_pkg::VAL_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.re) begin
            rd_data_reg <= (wr.we && wr.addr == rd.addr) ? wr.data : mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: hw/rtl/chcc_seq.sv
// Search sequencer: config registers, search state and per-word decisions at accept.
`timescale 1ns / 1ps
`default_nettype none
module chcc_seq (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [1:0]                      cfg_index,
    input  wire logic [chcc_pkg::STEP_W-1:0]     cfg_data,
    input  wire logic                            s_tvalid,
    input  wire logic [1:0]                      mode,
    input  wire logic [chcc_pkg::VAR_AW-1:0]     var_index,
    input  wire logic [chcc_pkg::VAL_W-1:0]      var_value,
    input  wire logic [chcc_pkg::COST_W-1:0]     cost_value,
    input  wire logic                            st1_free,
    output logic                                 s_tready,
    output logic                                 fire,
    output chcc_pkg::item_t                      item,
    output chcc_pkg::mem_rd_t                    mem_rd
);

    logic [chcc_pkg::CNT_W-1:0]  num_vars_reg;
    logic [chcc_pkg::STEP_W-1:0] init_step_reg;
    logic [chcc_pkg::STEP_W-1:0] stop_step_reg;

    logic                         running_reg, running_next;
    logic [chcc_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [chcc_pkg::COST_W-1:0]  cur_cost_reg, cur_cost_next;
    logic [chcc_pkg::COST_W-1:0]  best_cost_reg, best_cost_next;
    logic [chcc_pkg::VAR_AW-1:0]  best_idx_reg, best_idx_next;
    logic                         best_neg_reg, best_neg_next;
    logic [chcc_pkg::VAR_AW-1:0]  probe_idx_reg, probe_idx_next;
    logic                         probe_neg_reg, probe_neg_next;

    logic                         accept;
    logic [chcc_pkg::CNT_W-1:0]   n_act;
    logic [chcc_pkg::CNT_W-1:0]   pnext;
    logic                         nb;
    logic [chcc_pkg::COST_W-1:0]  bc;
    logic [chcc_pkg::VAR_AW-1:0]  bi;
    logic                         bn;
    logic [chcc_pkg::STEP_W-1:0]  step_h;

    assign s_tready = st1_free;
    assign accept = s_tvalid && s_tready;
    assign fire = accept && item.op != chcc_pkg::OP_NONE;

    assign n_act = (num_vars_reg > chcc_pkg::CNT_W'(chcc_pkg::MAX_VARS))
                   ? chcc_pkg::CNT_W'(chcc_pkg::MAX_VARS) : num_vars_reg;
    assign pnext = {1'b0, probe_idx_reg} + chcc_pkg::CNT_W'(1);
    assign nb = cost_value < best_cost_reg;
    assign bc = nb ? cost_value : best_cost_reg;
    assign bi = nb ? probe_idx_reg : best_idx_reg;
    assign bn = nb ? probe_neg_reg : best_neg_reg;
    assign step_h = (bc > cur_cost_reg) ? {1'b0, step_reg[chcc_pkg::STEP_W-1:1]} : step_reg;

    always_comb begin
        running_next = running_reg;
        step_next = step_reg;
        cur_cost_next = cur_cost_reg;
        best_cost_next = best_cost_reg;
        best_idx_next = best_idx_reg;
        best_neg_next = best_neg_reg;
        probe_idx_next = probe_idx_reg;
        probe_neg_next = probe_neg_reg;
        item = '0;
        item.op = chcc_pkg::OP_NONE;
        mem_rd = '0;
        case (mode)
            chcc_pkg::MODE_LOAD: begin
                item.op = chcc_pkg::OP_LOAD;
                item.idx = var_index;
                item.value = var_value;
            end
            chcc_pkg::MODE_START: begin
                cur_cost_next = cost_value;
                step_next = init_step_reg;
                item.cost = cost_value;
                item.step_a = init_step_reg;
                if (cost_value < chcc_pkg::COST_ONE || n_act == '0 ||
                    init_step_reg < stop_step_reg) begin
                    running_next = 1'b0;
                    item.op = chcc_pkg::OP_FIN;
                end else begin
                    running_next = 1'b1;
                    best_cost_next = chcc_pkg::COST_CEILING;
                    best_idx_next = '0;
                    best_neg_next = 1'b0;
                    probe_idx_next = '0;
                    probe_neg_next = 1'b0;
                    item.op = chcc_pkg::OP_START;
                    mem_rd.re = 1'b1;
                end
            end
            chcc_pkg::MODE_REPORT: begin
                if (running_reg) begin
                    best_cost_next = bc;
                    best_idx_next = bi;
                    best_neg_next = bn;
                    item.pidx = probe_idx_reg;
                    item.newbest = nb;
                    item.step_a = step_reg;
                    if (!probe_neg_reg) begin
                        probe_neg_next = 1'b1;
                        item.op = chcc_pkg::OP_NEG;
                    end else if (pnext < n_act) begin
                        probe_idx_next = pnext[chcc_pkg::VAR_AW-1:0];
                        probe_neg_next = 1'b0;
                        item.op = chcc_pkg::OP_NEXT;
                        item.idx = pnext[chcc_pkg::VAR_AW-1:0];
                        mem_rd.re = 1'b1;
                        mem_rd.addr = pnext[chcc_pkg::VAR_AW-1:0];
                    end else if (bc == cur_cost_reg) begin
                        running_next = 1'b0;
                        item.op = chcc_pkg::OP_RFIN;
                        item.cost = cur_cost_reg;
                    end else begin
                        step_next = step_h;
                        cur_cost_next = bc;
                        item.idx = bi;
                        item.neg_b = bn;
                        item.step_b = step_h;
                        item.cost = bc;
                        if (step_h < stop_step_reg || n_act == '0) begin
                            running_next = 1'b0;
                            item.op = chcc_pkg::OP_CFIN;
                        end else begin
                            best_cost_next = chcc_pkg::COST_CEILING;
                            best_idx_next = '0;
                            best_neg_next = 1'b0;
                            probe_idx_next = '0;
                            probe_neg_next = 1'b0;
                            item.op = chcc_pkg::OP_CNEXT;
                            mem_rd.re = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        mem_rd.re = mem_rd.re && accept;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_vars_reg <= '0;
            init_step_reg <= chcc_pkg::INIT_STEP_RST;
            stop_step_reg <= chcc_pkg::STOP_STEP_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                chcc_pkg::CFG_NUM_VARS:  num_vars_reg <= cfg_data[chcc_pkg::CNT_W-1:0];
                chcc_pkg::CFG_INIT_STEP: init_step_reg <= cfg_data;
                chcc_pkg::CFG_STOP_STEP: stop_step_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            step_reg <= '0;
            cur_cost_reg <= '0;
            best_cost_reg <= '0;
            best_idx_reg <= '0;
            best_neg_reg <= 1'b0;
            probe_idx_reg <= '0;
            probe_neg_reg <= 1'b0;
        end else if (accept) begin
            running_reg <= running_next;
            step_reg <= step_next;
            cur_cost_reg <= cur_cost_next;
            best_cost_reg <= best_cost_next;
            best_idx_reg <= best_idx_next;
            best_neg_reg <= best_neg_next;
            probe_idx_reg <= probe_idx_next;
            probe_neg_reg <= probe_neg_next;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/chcc_emit.sv
// Execute stage: probe values from the store, store writes of loads and committed moves, result words.
`timescale 1ns / 1ps
`default_nettype none
module chcc_emit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            fire,
    input  wire chcc_pkg::item_t                 item,
    input  wire logic [chcc_pkg::VAL_W-1:0]      rd_data,
    output chcc_pkg::mem_wr_t                    mem_wr,
    output logic                                 st1_free,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [79:0]                          m_tdata,   // out_index, out_value, final_cost
    output logic [1:0]                           m_tuser,   // action
    output logic                                 m_tlast
);

    logic                         st1_valid_reg;
    chcc_pkg::item_t              st1_reg;
    logic                         st1_adv;

    logic [chcc_pkg::VAL_W-1:0]   base_reg;
    logic [chcc_pkg::VAR_AW-1:0]  base_idx_reg;
    logic [chcc_pkg::VAL_W-1:0]   bbase_reg;
    logic [chcc_pkg::VAR_AW-1:0]  bbase_idx_reg;

    logic                         ob_valid_reg;
    logic [1:0]                   ob_cnt_reg;
    logic [1:0]                   ob_pos_reg;
    chcc_pkg::res_t               ob_reg [chcc_pkg::NRES];
    chcc_pkg::res_t               ob_cur;
    logic                         ob_last;
    logic                         ob_free;

    chcc_pkg::res_t               res [chcc_pkg::NRES];
    logic [1:0]                   res_cnt;
    logic [chcc_pkg::VAL_W-1:0]   bval;
    logic [chcc_pkg::VAL_W-1:0]   wval;
    logic [chcc_pkg::VAL_W-1:0]   src0;
    chcc_pkg::res_t               r_restore;
    chcc_pkg::res_t               r_done;

    assign ob_cur = ob_reg[ob_pos_reg];
    assign ob_last = ob_pos_reg == ob_cnt_reg - 2'd1;
    assign ob_free = !ob_valid_reg || (m_tready && ob_last);
    assign st1_adv = st1_valid_reg && (st1_reg.op == chcc_pkg::OP_LOAD || ob_free);
    assign st1_free = !st1_valid_reg || st1_adv;

    assign m_tvalid = ob_valid_reg;
    assign m_tuser = ob_cur.act;
    assign m_tdata = {4'b0000, ob_cur.cost, ob_cur.val, ob_cur.idx};
    assign m_tlast = ob_last;

    assign bval = st1_reg.newbest ? base_reg : bbase_reg;
    assign wval = chcc_pkg::moved(bval, st1_reg.neg_b, st1_reg.step_a);
    assign src0 = (st1_reg.op == chcc_pkg::OP_CNEXT && st1_reg.idx == '0) ? wval : rd_data;

    always_comb begin
        r_restore = '{act: chcc_pkg::ACT_SET, idx: st1_reg.pidx, val: base_reg, cost: '0};
        r_done = '{act: chcc_pkg::ACT_DONE, idx: '0, val: '0, cost: st1_reg.cost};
        for (int i = 0; i < chcc_pkg::NRES; i++) begin
            res[i] = '{act: chcc_pkg::ACT_EVAL, idx: '0, val: '0, cost: '0};
        end
        res_cnt = 2'd0;
        mem_wr = '0;
        case (st1_reg.op) inside
            chcc_pkg::OP_LOAD: begin
                mem_wr.we = 1'b1;
                mem_wr.addr = st1_reg.idx;
                mem_wr.data = st1_reg.value;
            end
            chcc_pkg::OP_FIN: begin
                res[0] = r_done;
                res_cnt = 2'd1;
            end
            chcc_pkg::OP_START: begin
                res[0].val = chcc_pkg::moved(rd_data, 1'b0, st1_reg.step_a);
                res_cnt = 2'd1;
            end
            chcc_pkg::OP_NEG: begin
                res[0] = r_restore;
                res[1].idx = st1_reg.pidx;
                res[1].val = chcc_pkg::moved(base_reg, 1'b1, st1_reg.step_a);
                res_cnt = 2'd2;
            end
            chcc_pkg::OP_NEXT: begin
                res[0] = r_restore;
                res[1].idx = st1_reg.idx;
                res[1].val = chcc_pkg::moved(rd_data, 1'b0, st1_reg.step_a);
                res_cnt = 2'd2;
            end
            chcc_pkg::OP_RFIN: begin
                res[0] = r_restore;
                res[1] = r_done;
                res_cnt = 2'd2;
            end
            chcc_pkg::OP_CFIN, chcc_pkg::OP_CNEXT: begin
                mem_wr.we = 1'b1;
                mem_wr.addr = st1_reg.idx;
                mem_wr.data = wval;
                res[0] = r_restore;
                res[1] = '{act: chcc_pkg::ACT_SET, idx: st1_reg.idx, val: wval, cost: '0};
                if (st1_reg.op == chcc_pkg::OP_CFIN) begin
                    res[2] = r_done;
                end else begin
                    res[2].val = chcc_pkg::moved(src0, 1'b0, st1_reg.step_b);
                end
                res_cnt = 2'd3;
            end
            default: begin
            end
        endcase
        mem_wr.we = mem_wr.we && st1_adv;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (fire) begin
            st1_valid_reg <= 1'b1;
        end else if (st1_adv) begin
            st1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            st1_reg <= item;
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_adv) begin
            case (st1_reg.op) inside
                chcc_pkg::OP_LOAD: begin
                    if (st1_reg.idx == base_idx_reg) begin
                        base_reg <= st1_reg.value;
                    end
                    if (st1_reg.idx == bbase_idx_reg) begin
                        bbase_reg <= st1_reg.value;
                    end
                end
                chcc_pkg::OP_START, chcc_pkg::OP_CNEXT: begin
                    base_reg <= src0;
                    base_idx_reg <= '0;
                    bbase_reg <= src0;
                    bbase_idx_reg <= '0;
                end
                chcc_pkg::OP_NEG, chcc_pkg::OP_NEXT: begin
                    if (st1_reg.newbest) begin
                        bbase_reg <= base_reg;
                        bbase_idx_reg <= base_idx_reg;
                    end
                    if (st1_reg.op == chcc_pkg::OP_NEXT) begin
                        base_reg <= rd_data;
                        base_idx_reg <= st1_reg.idx;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ob_valid_reg <= 1'b0;
            ob_cnt_reg <= 2'd0;
            ob_pos_reg <= 2'd0;
        end else if (st1_adv && res_cnt != 2'd0) begin
            ob_valid_reg <= 1'b1;
            ob_cnt_reg <= res_cnt;
            ob_pos_reg <= 2'd0;
        end else if (ob_valid_reg && m_tready) begin
            if (ob_last) begin
                ob_valid_reg <= 1'b0;
            end else begin
                ob_pos_reg <= ob_pos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_adv && res_cnt != 2'd0) begin
            for (int i = 0; i < chcc_pkg::NRES; i++) begin
                ob_reg[i] <= res[i];
            end
        end
    end

    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ob_valid_reg |-> (ob_pos_reg < ob_cnt_reg))
        else $error("result position beyond word count");

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == chcc_pkg::ACT_DONE) |-> m_tlast)
        else $error("finished word not marked last");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (st1_valid_reg && !st1_adv) |=> (st1_valid_reg && $stable(st1_reg)))
        else $error("stalled execute stage lost its word");

    a_write_on_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr.we |-> (st1_valid_reg && st1_free))
        else $error("store write without stage advance");

endmodule
`default_nettype wire

// File: hw/rtl/coordinate_hill_climb_controller_unit.sv
// Top level of the coordinate hill-climb search controller.
// Usage:
//   s_ channel words: tuser = mode (load variable, start with cost, probe cost report),
//   tdata = var_index, var_value, cost_value. cfg_we/cfg_index/cfg_data write num_vars,
//   init_step and stop_step; write them only while no search word is in flight.
//   m_ channel words: tuser = action (set and evaluate, set only, finished), tdata =
//   out_index, out_value, final_cost; tlast marks the last word caused by one input word.
// Path: an accepted input word is registered in the execute stage, and then its result
//   words are registered in the output buffer, from which they are offered on the m_ channel.
// Throughput: one input word per cycle while the output keeps up; each input word holds
//   the output until its result words (one to three) are taken; loads have none.
//   The bound is the output, one word per cycle while m_tready is high; the store's single
//   read and single write port never hold up the flow.
// Reset: aresetn (synchronous, active low) idles the search, clears the step and costs,
//   and restores the register defaults; variable contents stay undefined until loaded.
// Stall: while m_tready is low the pending result words hold, the execute stage holds any
//   word but a load, and s_tready drops while that stage holds a word it cannot pass on;
//   nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module coordinate_hill_climb_controller_unit (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [30:0]   cfg_data,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [79:0]   s_tdata,   // var_index, var_value, cost_value
    input  wire logic [1:0]    s_tuser,   // mode
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [79:0]        m_tdata,   // out_index, out_value, final_cost
    output logic [1:0]         m_tuser,   // action
    output logic               m_tlast
);

    logic                          fire;
    logic                          st1_free;
    chcc_pkg::item_t               item;
    chcc_pkg::mem_rd_t             mem_rd;
    chcc_pkg::mem_wr_t             mem_wr;
    logic [chcc_pkg::VAL_W-1:0]    rd_data;

    chcc_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .mode       (s_tuser),
        .var_index  (s_tdata[3:0]),
        .var_value  (s_tdata[35:4]),
        .cost_value (s_tdata[75:36]),
        .st1_free   (st1_free),
        .s_tready   (s_tready),
        .fire       (fire),
        .item       (item),
        .mem_rd     (mem_rd)
    );

    chcc_var_mem u_mem (
        .aclk    (aclk),
        .rd      (mem_rd),
        .wr      (mem_wr),
        .rd_data (rd_data)
    );

    chcc_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (fire),
        .item     (item),
        .rd_data  (rd_data),
        .mem_wr   (mem_wr),
        .st1_free (st1_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire
